// ----- rtl/core/mep_pkg.sv -----
// shared types and constants for the escape-time pixel core
// no dependencies
package mep_pkg;

	localparam int FRAC_BITS_DEF = 28;
	localparam int COORD_BITS    = 12;
	localparam int ITER_BITS     = 16;
	localparam int SIZE_BITS     = 13;
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_IDX_BITS  = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_ZOOM_FACTOR  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_RE    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_IM    = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_ITER_LIMIT   = 3'd5;

	typedef struct packed {
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
	} pix_in_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] out_x;
		logic [COORD_BITS-1:0] out_y;
		logic [23:0]           pixel_rgb;
	} pix_out_t;

endpackage

// ----- rtl/core/mandelbrot_escape_pixel_core.sv -----
// mandelbrot escape-time pixel core: maps a pixel to c, iterates z = z*z + c, colors it
// one shared multiplier and one restoring divide step under a one-hot sequencer
// depends on mep_pkg
// a saturated mapping skips its divide
// one pixel in flight: the next word is taken only once idle and out_valid has dropped
// each escape iteration steps IT_UPD, IT_XX, IT_YY, IT_CHK: three products, one multiplier
// each axis mapping takes FRAC_BITS+4 divide steps, the color division ten steps
// arst_n clears the sequencer and output valid and loads the register defaults
module mandelbrot_escape_pixel_core #(
	parameter int FRAC_BITS = mep_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [mep_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [mep_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  mep_pkg::pix_in_t                    in_word,
	output logic                                out_valid,
	input  logic                                out_stall,
	output mep_pkg::pix_out_t                   out_word
);
	import mep_pkg::*;

	localparam int W      = FRAC_BITS + 4;
	localparam int MUL_W  = (W > 32) ? W : 32;
	localparam int P_W    = 2 * MUL_W;
	localparam int DEN_W  = 32 + SIZE_BITS;
	localparam int REM_W  = DEN_W + 1;
	localparam int COL_QB = 10;
	localparam int CNT_W  = $clog2(W + 1);
	localparam int UP_SH  = (FRAC_BITS >= 28) ? FRAC_BITS - 28 : 0;
	localparam int DN_SH  = (FRAC_BITS >= 28) ? 0 : 28 - FRAC_BITS;
	localparam int DVD_W  = ITER_BITS + 9;

	localparam logic [W-1:0] FMT_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] FMT_MIN = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] FOUR    = W'(64'd4 << FRAC_BITS);

	typedef enum logic [11:0] {
		ST_IDLE     = 12'b000000000001,
		ST_DEN      = 12'b000000000010,
		ST_CHK      = 12'b000000000100,
		ST_DIV      = 12'b000000001000,
		ST_MAP_FIN  = 12'b000000010000,
		ST_IT_XY    = 12'b000000100000,
		ST_IT_UPD   = 12'b000001000000,
		ST_IT_XX    = 12'b000010000000,
		ST_IT_YY    = 12'b000100000000,
		ST_IT_CHK   = 12'b001000000000,
		ST_COL_INIT = 12'b010000000000,
		ST_COL_FIN  = 12'b100000000000
	} state_t;

	function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1])
			return s[W] ? FMT_MIN : FMT_MAX;
		return s[W-1:0];
	endfunction

	function automatic logic [W-1:0] sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [W:0] s;
		s = {a[W-1], a} - {b[W-1], b};
		if (s[W] != s[W-1])
			return s[W] ? FMT_MIN : FMT_MAX;
		return s[W-1:0];
	endfunction

	function automatic logic [MUL_W-1:0] mag(input logic [W-1:0] v);
		logic [W-1:0] m;
		m = v[W-1] ? (~v + W'(1)) : v;
		return MUL_W'(m);
	endfunction

	function automatic logic [W-1:0] qmul(input logic [P_W-1:0] p, input logic neg);
		logic [P_W-1:0] hi;
		logic [P_W-1:0] q1;
		logic           inexact;
		hi      = p >> FRAC_BITS;
		inexact = (p & ((P_W'(1) << FRAC_BITS) - P_W'(1))) != '0;
		if (!neg) begin
			if (hi > P_W'(FMT_MAX))
				return FMT_MAX;
			return hi[W-1:0];
		end
		q1 = hi + P_W'(inexact);
		if (q1 > P_W'(FMT_MIN))
			return FMT_MIN;
		return ~q1[W-1:0] + W'(1);
	endfunction

	function automatic logic [W-1:0] center_fmt(input logic [31:0] c);
		logic signed [95:0] e;
		e = 96'(signed'(c));
		e = (e <<< UP_SH) >>> DN_SH;
		return e[W-1:0];
	endfunction

	// configuration registers
	logic [SIZE_BITS-1:0] width_q, height_q;
	logic [31:0]          zoom_q, cen_re_q, cen_im_q;
	logic [ITER_BITS-1:0] lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_BITS'(800);
			height_q <= SIZE_BITS'(800);
			zoom_q   <= 32'd65536;
			cen_re_q <= '0;
			cen_im_q <= '0;
			lim_q    <= ITER_BITS'(100);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[SIZE_BITS-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[SIZE_BITS-1:0];
				REG_ZOOM_FACTOR:  zoom_q   <= cfg_data;
				REG_CENTER_RE:    cen_re_q <= cfg_data;
				REG_CENTER_IM:    cen_im_q <= cfg_data;
				REG_ITER_LIMIT:   lim_q    <= cfg_data[ITER_BITS-1:0];
				default: ;
			endcase
		end
	end

	state_t                st_q;
	logic                  axis_q, mode_col_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [COORD_BITS-1:0] px_q, py_q;
	logic [P_W-1:0]        prod_q;
	logic [DEN_W-1:0]      den_q;
	logic [REM_W-1:0]      rem_q;
	logic [W-1:0]          quo_q;
	logic [COL_QB-1:0]     dvd_q;
	logic                  zero_q, ovf_q, neg_q, nz_q;
	logic [W-1:0]          cre_q, cim_q, zx_q, zy_q, xx_q, yy_q;
	logic [ITER_BITS:0]    i_q;
	logic                  out_valid_q;
	pix_out_t              out_q;

	logic [MUL_W-1:0]     mul_a, mul_b;
	logic [SIZE_BITS-1:0] size_sel;
	logic [COORD_BITS-1:0] pix_sel;
	logic [SIZE_BITS:0]   num;
	logic [SIZE_BITS-1:0] num_mag;
	logic [REM_W-1:0]     num_sh;
	logic [REM_W-1:0]     r2;
	logic                 ge;
	logic [W-1:0]         q1_pos;
	logic [W:0]           q1_neg;
	logic [W-1:0]         term, off, mapped;
	logic [W-1:0]         xy, nx, ny, yy_new, mag2;
	logic                 esc;
	logic [DVD_W-1:0]     dvd;
	logic [9:0]           color;
	logic                 in_acc;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (st_q != ST_IDLE) || out_valid_q;

	always_comb begin
		size_sel = axis_q ? height_q : width_q;
		pix_sel  = axis_q ? py_q : px_q;
		num      = {1'b0, pix_sel, 1'b0} - {1'b0, size_sel};
		num_mag  = num[SIZE_BITS] ? SIZE_BITS'(~num + 1'b1) : num[SIZE_BITS-1:0];
		num_sh   = REM_W'({num_mag, 12'b0});
		off      = axis_q ? center_fmt(cen_im_q) : center_fmt(cen_re_q);
	end

	// shared multiplier operands
	always_comb begin
		case (st_q)
			ST_DEN: begin
				mul_a = MUL_W'(zoom_q);
				mul_b = MUL_W'(size_sel);
			end
			ST_IT_XY, ST_IT_CHK: begin
				mul_a = mag(zx_q);
				mul_b = mag(zy_q);
			end
			ST_IT_XX: begin
				mul_a = mag(zx_q);
				mul_b = mag(zx_q);
			end
			ST_IT_YY: begin
				mul_a = mag(zy_q);
				mul_b = mag(zy_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// divide step, mapping term and iteration math
	always_comb begin
		r2     = {rem_q[REM_W-2:0], dvd_q[COL_QB-1]};
		ge     = r2 >= {1'b0, den_q};
		q1_pos = quo_q;
		q1_neg = {1'b0, quo_q} + (W+1)'(rem_q != '0);
		if (zero_q)
			term = nz_q ? (neg_q ? FMT_MIN : FMT_MAX) : '0;
		else if (ovf_q)
			term = neg_q ? FMT_MIN : FMT_MAX;
		else if (!neg_q)
			term = q1_pos[W-1] ? FMT_MAX : q1_pos;
		else
			term = (q1_neg > (W+1)'(FMT_MIN)) ? FMT_MIN : (~q1_neg[W-1:0] + W'(1));
		mapped = sat_add(term, off);
		xy     = qmul(prod_q, zx_q[W-1] ^ zy_q[W-1]);
		nx     = sat_add(sat_sub(xx_q, yy_q), cre_q);
		ny     = sat_add(sat_add(xy, xy), cim_q);
		yy_new = qmul(prod_q, 1'b0);
		mag2   = sat_add(xx_q, yy_new);
		esc    = $signed(mag2) > $signed(FOUR);
		dvd    = (DVD_W'(i_q) << 8) - DVD_W'(i_q);
		color  = quo_q[COL_QB-1:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			axis_q      <= 1'b0;
			mode_col_q  <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						axis_q <= 1'b0;
						st_q   <= ST_DEN;
					end
				end
				ST_DEN: st_q <= ST_CHK;
				ST_CHK: begin
					mode_col_q <= 1'b0;
					cnt_q      <= CNT_W'(W);
					if (prod_q[DEN_W-1:0] == '0 || num_sh >= REM_W'(prod_q[DEN_W-1:0]))
						st_q <= ST_MAP_FIN;
					else
						st_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1))
						st_q <= mode_col_q ? ST_COL_FIN : ST_MAP_FIN;
				end
				ST_MAP_FIN: begin
					if (!axis_q) begin
						axis_q <= 1'b1;
						st_q   <= ST_DEN;
					end else if (lim_q == '0) begin
						out_valid_q <= 1'b1;
						st_q        <= ST_IDLE;
					end else begin
						st_q <= ST_IT_XY;
					end
				end
				ST_IT_XY:  st_q <= ST_IT_UPD;
				ST_IT_UPD: st_q <= ST_IT_XX;
				ST_IT_XX:  st_q <= ST_IT_YY;
				ST_IT_YY:  st_q <= ST_IT_CHK;
				ST_IT_CHK: begin
					if (esc || i_q == {1'b0, lim_q})
						st_q <= ST_COL_INIT;
					else
						st_q <= ST_IT_UPD;
				end
				ST_COL_INIT: begin
					mode_col_q <= 1'b1;
					cnt_q      <= CNT_W'(COL_QB);
					st_q       <= ST_DIV;
				end
				ST_COL_FIN: begin
					out_valid_q <= 1'b1;
					st_q        <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (in_acc) begin
					px_q <= in_word.pixel_x;
					py_q <= in_word.pixel_y;
				end
			end
			ST_CHK: begin
				den_q  <= prod_q[DEN_W-1:0];
				rem_q  <= num_sh;
				dvd_q  <= '0;
				quo_q  <= '0;
				zero_q <= prod_q[DEN_W-1:0] == '0;
				ovf_q  <= num_sh >= REM_W'(prod_q[DEN_W-1:0]);
				neg_q  <= num[SIZE_BITS];
				nz_q   <= num != '0;
			end
			ST_DIV: begin
				rem_q <= ge ? (r2 - {1'b0, den_q}) : r2;
				quo_q <= {quo_q[W-2:0], ge};
				dvd_q <= dvd_q << 1;
			end
			ST_MAP_FIN: begin
				if (axis_q)
					cim_q <= mapped;
				else
					cre_q <= mapped;
				zx_q <= '0;
				zy_q <= '0;
				xx_q <= '0;
				yy_q <= '0;
				i_q  <= (ITER_BITS+1)'(1);
				out_q.out_x     <= px_q;
				out_q.out_y     <= py_q;
				out_q.pixel_rgb <= '0;
			end
			ST_IT_UPD: begin
				zx_q <= nx;
				zy_q <= ny;
			end
			ST_IT_YY: xx_q <= qmul(prod_q, 1'b0);
			ST_IT_CHK: begin
				yy_q <= yy_new;
				if (!esc)
					i_q <= i_q + 1'b1;
			end
			ST_COL_INIT: begin
				rem_q <= REM_W'(dvd >> COL_QB);
				dvd_q <= dvd[COL_QB-1:0];
				den_q <= DEN_W'(lim_q);
				quo_q <= '0;
			end
			ST_COL_FIN: begin
				out_q.pixel_rgb <= {8'((color << 3) + color), 8'(color << 1),
					8'((color << 2) + color)};
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> st_q == ST_DEN)
		else $error("accepted word did not start the mapping");
	a_accept_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> !out_valid_q)
		else $error("word accepted while a result was pending");
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DIV |-> cnt_q != '0)
		else $error("divide step with empty counter");
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q == ST_COL_FIN || st_q == ST_MAP_FIN))
		else $error("result raised outside the finish states");
endmodule
